### rtl/core/env_sensor_trim_compensation_defines.svh
// ============================================================================
// Assertion macros for the trim compensation block
// Shared concurrent check forms, clocked on clock and disabled during reset.
// ============================================================================
`ifndef ENV_SENSOR_TRIM_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_TRIM_COMPENSATION_DEFINES_SVH

// Same-cycle implication check.
`define ESTC_CHECK_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define ESTC_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/estc_pkg.sv
// ============================================================================
// Trim compensation package
// Shared types, codes and sign handling helpers of the compensation block.
// ============================================================================
`timescale 1ns / 1ps

package estc_pkg;

   // Shared arithmetic unit operations.
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_TRIM       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_NINE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_TRIM        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_PRESENT     = 3'd5;

   // Skipped-channel markers and output limits.
   localparam logic [23:0] SKIP24       = 24'h800000;
   localparam logic [15:0] SKIP16       = 16'h8000;
   localparam logic [16:0] HUM_Q10_MAX  = 17'd102400;
   localparam logic [31:0] HUM_RAW_MAX  = 32'd419430400;
   localparam logic [31:0] PRESS_FALLBACK = 32'd960000;

   typedef struct packed {
      logic [47:0] temp_trim;
      logic [63:0] press_trim_low;
      logic [63:0] press_trim_high;
      logic [15:0] press_trim_nine;
      logic [63:0] hum_trim;
      logic        humidity_present;
   } trim_type;

   typedef struct packed {
      logic start;
      logic op;
   } arith_cmd_type;

   typedef struct packed {
      logic [31:0] fine_temp;
      logic        temp_ok;
      logic [31:0] pressure_q5;
      logic        press_ok;
      logic [16:0] humidity_q10;
      logic        hum_ok;
   } result_type;

   function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [63:0] sx16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

endpackage

### rtl/core/estc_arith.sv
// ============================================================================
// Shared multiply and divide unit
// Wrapping 64-bit multiply, 16 multiplier bits per cycle, and
// signed 64-bit division truncating toward zero, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module estc_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  estc_pkg::arith_cmd_type cmd,
   input  logic [63:0]            opa,
   input  logic [63:0]            opb,
   output logic                   done,
   output logic [63:0]            result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        op_ff, op_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] rem_sh;
   logic        fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      rem_sh  = {acc_ff[62:0], a_ff[63]};
      fits    = rem_sh >= b_ff;
      if (cmd.start) begin
         // Latch operands; the divider works on magnitudes.
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         acc_in  = '0;
         if (cmd.op == estc_pkg::OP_DIV) begin
            neg_in = opa[63] ^ opb[63];
            a_in   = opa[63] ? 64'(0 - opa) : opa;
            b_in   = opb[63] ? 64'(0 - opb) : opb;
         end else begin
            a_in = opa;
            b_in = opb;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (op_ff == estc_pkg::OP_MUL) begin
            // One 64 by 16 partial product per cycle.
            acc_in = acc_ff + 64'(a_ff * {48'd0, b_ff[15:0]});
            a_in   = {a_ff[47:0], 16'd0};
            b_in   = {16'd0, b_ff[63:16]};
            if (cnt_ff == 6'd3) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = acc_in;
            end
         end else begin
            // Restoring division step; the quotient shifts into a_ff.
            acc_in = fits ? 64'(rem_sh - b_ff) : rem_sh;
            a_in   = {a_ff[62:0], fits};
            if (cnt_ff == 6'd63) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = neg_ff ? 64'(0 - a_in) : a_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### rtl/core/estc_seq.sv
// ============================================================================
// Compensation sequencer
// Steps one reading through temperature, pressure and humidity, feeding the
// shared arithmetic unit and folding each product into the running terms.
// ============================================================================
`timescale 1ns / 1ps

module estc_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [23:0]             raw_temp,
   input  logic [23:0]             raw_press,
   input  logic [15:0]             raw_hum,
   input  estc_pkg::trim_type      trim,
   input  logic                    take,
   output logic                    idle,
   output logic                    res_valid,
   output estc_pkg::result_type    result,
   output estc_pkg::arith_cmd_type cmd,
   output logic [63:0]             opa,
   output logic [63:0]             opb,
   input  logic                    arith_done,
   input  logic [63:0]             arith_res
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] T_M1    = 5'd1;
   localparam logic [4:0] T_M2    = 5'd2;
   localparam logic [4:0] T_M3    = 5'd3;
   localparam logic [4:0] P_AA    = 5'd4;
   localparam logic [4:0] P_B1    = 5'd5;
   localparam logic [4:0] P_B2    = 5'd6;
   localparam logic [4:0] P_C1    = 5'd7;
   localparam logic [4:0] P_C2    = 5'd8;
   localparam logic [4:0] P_D     = 5'd9;
   localparam logic [4:0] P_N     = 5'd10;
   localparam logic [4:0] P_DIV   = 5'd11;
   localparam logic [4:0] P_E1    = 5'd12;
   localparam logic [4:0] P_E2    = 5'd13;
   localparam logic [4:0] P_F     = 5'd14;
   localparam logic [4:0] H_M1    = 5'd15;
   localparam logic [4:0] H_G1    = 5'd16;
   localparam logic [4:0] H_G2    = 5'd17;
   localparam logic [4:0] H_B     = 5'd18;
   localparam logic [4:0] H_BH2   = 5'd19;
   localparam logic [4:0] H_AB    = 5'd20;
   localparam logic [4:0] H_SS    = 5'd21;
   localparam logic [4:0] H_T     = 5'd22;
   localparam logic [4:0] S_DONE  = 5'd23;

   logic [4:0]  step_ff, step_in;
   logic        issued_ff, issued_in;
   logic [31:0] fine_hold_ff, fine_hold_in;
   logic [23:0] rt_ff, rt_in;
   logic [23:0] rp_ff, rp_in;
   logic [15:0] rh_ff, rh_in;
   logic        tok_ff, tok_in, pok_ff, pok_in, hok_ff, hok_in;
   logic [31:0] fine_out_ff, fine_out_in;
   logic [31:0] press_out_ff, press_out_in;
   logic [16:0] hum_out_ff, hum_out_in;
   logic [63:0] tv1_ff, tv1_in, tm2_ff, tm2_in;
   logic [63:0] aa_ff, aa_in, pb_ff, pb_in, a2_ff, a2_in, a3_ff, a3_in;
   logic [63:0] n_ff, n_in, p_ff, p_in, e_ff, e_in;
   logic [31:0] ha_ff, ha_in, hg_ff, hg_in, hb_ff, hb_in, hv_ff, hv_in, hs_ff, hs_in;

   logic [63:0] t1, t2, t3, d1, d2;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0] pa, pp, ps13, psum;
   logic [31:0] pt, fine_new;
   logic [31:0] h1, h2, h3, h4, h5, h6, hx, r32, hv_fin, hum_c;
   logic [4:0]  nxt_hum, nxt_press;
   logic        tok_now, pok_now, hok_now;

   // Coefficient fields and derived operands.
   always_comb begin
      t1 = {48'd0, trim.temp_trim[15:0]};
      t2 = estc_pkg::sx16(trim.temp_trim[31:16]);
      t3 = estc_pkg::sx16(trim.temp_trim[47:32]);
      d1 = {47'd0, rt_ff[23:7]} - {47'd0, trim.temp_trim[15:0], 1'b0};
      d2 = {48'd0, rt_ff[23:8]} - t1;
      p1 = {48'd0, trim.press_trim_low[15:0]};
      p2 = estc_pkg::sx16(trim.press_trim_low[31:16]);
      p3 = estc_pkg::sx16(trim.press_trim_low[47:32]);
      p4 = estc_pkg::sx16(trim.press_trim_low[63:48]);
      p5 = estc_pkg::sx16(trim.press_trim_high[15:0]);
      p6 = estc_pkg::sx16(trim.press_trim_high[31:16]);
      p7 = estc_pkg::sx16(trim.press_trim_high[47:32]);
      p8 = estc_pkg::sx16(trim.press_trim_high[63:48]);
      p9 = estc_pkg::sx16(trim.press_trim_nine);
      pa = estc_pkg::sx32(fine_hold_ff) - 64'd128000;
      pp = 64'd1048576 - {44'd0, rp_ff[23:4]};
      ps13 = estc_pkg::asr64(p_ff, 6'd13);
      h1 = {24'd0, trim.hum_trim[7:0]};
      h2 = {{16{trim.hum_trim[23]}}, trim.hum_trim[23:8]};
      h3 = {24'd0, trim.hum_trim[31:24]};
      h4 = {20'd0, trim.hum_trim[43:32]};
      h5 = {{20{trim.hum_trim[55]}}, trim.hum_trim[55:44]};
      h6 = {{24{trim.hum_trim[63]}}, trim.hum_trim[63:56]};
      hx = fine_hold_ff - 32'd76800;
      r32 = arith_res[31:0];
      nxt_hum   = hok_ff ? H_M1 : S_DONE;
      nxt_press = pok_ff ? P_AA : nxt_hum;
      tok_now = raw_temp != estc_pkg::SKIP24;
      pok_now = raw_press != estc_pkg::SKIP24;
      hok_now = trim.humidity_present && (raw_hum != estc_pkg::SKIP16);
      fine_new = 32'(tv1_ff + estc_pkg::asr64(arith_res, 6'd14));
      psum = p_ff + e_ff + estc_pkg::asr64(arith_res, 6'd19);
      pt = 32'(estc_pkg::asr64(psum, 6'd8)) + 32'(p7 << 4);
      hv_fin = hv_ff - estc_pkg::asr32(r32, 5'd4);
      if (hv_fin[31]) begin
         hum_c = '0;
      end else if (hv_fin > estc_pkg::HUM_RAW_MAX) begin
         hum_c = estc_pkg::HUM_RAW_MAX;
      end else begin
         hum_c = hv_fin;
      end
   end

   // Operand selection for the shared unit.
   always_comb begin
      unique case (step_ff)
         T_M1:    begin opa = d1; opb = t2; end
         T_M2:    begin opa = d2; opb = d2; end
         T_M3:    begin opa = estc_pkg::asr64(tm2_ff, 6'd12); opb = t3; end
         P_AA:    begin opa = pa; opb = pa; end
         P_B1:    begin opa = aa_ff; opb = p6; end
         P_B2:    begin opa = pa; opb = p5; end
         P_C1:    begin opa = aa_ff; opb = p3; end
         P_C2:    begin opa = pa; opb = p2; end
         P_D:     begin opa = (64'd1 << 47) + a2_ff; opb = p1; end
         P_N:     begin opa = (pp << 31) - pb_ff; opb = 64'd3125; end
         P_DIV:   begin opa = n_ff; opb = a3_ff; end
         P_E1:    begin opa = p9; opb = ps13; end
         P_E2:    begin opa = e_ff; opb = ps13; end
         P_F:     begin opa = p8; opb = p_ff; end
         H_M1:    begin opa = estc_pkg::sx32(h5); opb = estc_pkg::sx32(hx); end
         H_G1:    begin opa = estc_pkg::sx32(hx); opb = estc_pkg::sx32(h6); end
         H_G2:    begin opa = estc_pkg::sx32(hx); opb = estc_pkg::sx32(h3); end
         H_B:     begin opa = estc_pkg::sx32(hg_ff); opb = estc_pkg::sx32(hb_ff); end
         H_BH2:   begin opa = estc_pkg::sx32(hb_ff); opb = estc_pkg::sx32(h2); end
         H_AB:    begin opa = estc_pkg::sx32(ha_ff); opb = estc_pkg::sx32(hb_ff); end
         H_SS:    begin opa = estc_pkg::sx32(hs_ff); opb = estc_pkg::sx32(hs_ff); end
         H_T:     begin opa = estc_pkg::sx32(hs_ff); opb = estc_pkg::sx32(h1); end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   // Step sequencing and capture of each product.
   always_comb begin
      step_in      = step_ff;
      issued_in    = issued_ff;
      fine_hold_in = fine_hold_ff;
      rt_in = rt_ff;  rp_in = rp_ff;  rh_in = rh_ff;
      tok_in = tok_ff;  pok_in = pok_ff;  hok_in = hok_ff;
      fine_out_in  = fine_out_ff;
      press_out_in = press_out_ff;
      hum_out_in   = hum_out_ff;
      tv1_in = tv1_ff;  tm2_in = tm2_ff;
      aa_in = aa_ff;  pb_in = pb_ff;  a2_in = a2_ff;  a3_in = a3_ff;
      n_in = n_ff;  p_in = p_ff;  e_in = e_ff;
      ha_in = ha_ff;  hg_in = hg_ff;  hb_in = hb_ff;  hv_in = hv_ff;  hs_in = hs_ff;
      cmd.start = 1'b0;
      cmd.op    = (step_ff == P_DIV) ? estc_pkg::OP_DIV : estc_pkg::OP_MUL;
      unique case (step_ff)
         S_IDLE: begin
            if (start) begin
               rt_in = raw_temp;  rp_in = raw_press;  rh_in = raw_hum;
               tok_in = tok_now;  pok_in = pok_now;  hok_in = hok_now;
               fine_out_in = '0;  press_out_in = '0;  hum_out_in = '0;
               issued_in = 1'b0;
               if (tok_now) begin
                  step_in = T_M1;
               end else if (pok_now) begin
                  step_in = P_AA;
               end else if (hok_now) begin
                  step_in = H_M1;
               end else begin
                  step_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (take) begin
               step_in = S_IDLE;
            end
         end
         default: begin
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (arith_done) begin
               issued_in = 1'b0;
               step_in   = 5'(step_ff + 5'd1);
               unique case (step_ff)
                  T_M1:  tv1_in = estc_pkg::asr64(arith_res, 6'd11);
                  T_M2:  tm2_in = arith_res;
                  T_M3: begin
                     fine_hold_in = fine_new;
                     fine_out_in  = fine_new;
                     step_in      = nxt_press;
                  end
                  P_AA:  aa_in = arith_res;
                  P_B1:  pb_in = arith_res;
                  P_B2:  pb_in = pb_ff + (arith_res << 17) + (p4 << 35);
                  P_C1:  a2_in = estc_pkg::asr64(arith_res, 6'd8);
                  P_C2:  a2_in = a2_ff + (arith_res << 12);
                  P_D: begin
                     a3_in = estc_pkg::asr64(arith_res, 6'd33);
                     // Zero divisor: fall back to the fixed pressure.
                     if (a3_in == 64'd0) begin
                        press_out_in = estc_pkg::PRESS_FALLBACK;
                        step_in      = nxt_hum;
                     end
                  end
                  P_N:   n_in = arith_res;
                  P_DIV: p_in = arith_res;
                  P_E1:  e_in = arith_res;
                  P_E2:  e_in = estc_pkg::asr64(arith_res, 6'd25);
                  P_F: begin
                     press_out_in = estc_pkg::asr32(pt, 5'd3);
                     step_in      = nxt_hum;
                  end
                  H_M1: begin
                     ha_in = estc_pkg::asr32(
                        {2'd0, rh_ff, 14'd0} - {h4[11:0], 20'd0} - r32 + 32'd16384, 5'd15);
                  end
                  H_G1:  hg_in = estc_pkg::asr32(r32, 5'd10);
                  H_G2:  hb_in = estc_pkg::asr32(r32, 5'd11) + 32'd32768;
                  H_B:   hb_in = estc_pkg::asr32(r32, 5'd10) + 32'd2097152;
                  H_BH2: hb_in = estc_pkg::asr32(r32 + 32'd8192, 5'd14);
                  H_AB: begin
                     hv_in = r32;
                     hs_in = estc_pkg::asr32(r32, 5'd15);
                  end
                  H_SS:  hs_in = estc_pkg::asr32(r32, 5'd7);
                  H_T: begin
                     hum_out_in = hum_c[28:12];
                     step_in    = S_DONE;
                  end
                  default: step_in = S_DONE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_IDLE;
         issued_ff    <= 1'b0;
         fine_hold_ff <= '0;
      end else begin
         step_ff      <= step_in;
         issued_ff    <= issued_in;
         fine_hold_ff <= fine_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      rt_ff <= rt_in;  rp_ff <= rp_in;  rh_ff <= rh_in;
      tok_ff <= tok_in;  pok_ff <= pok_in;  hok_ff <= hok_in;
      fine_out_ff  <= fine_out_in;
      press_out_ff <= press_out_in;
      hum_out_ff   <= hum_out_in;
      tv1_ff <= tv1_in;  tm2_ff <= tm2_in;
      aa_ff <= aa_in;  pb_ff <= pb_in;  a2_ff <= a2_in;  a3_ff <= a3_in;
      n_ff <= n_in;  p_ff <= p_in;  e_ff <= e_in;
      ha_ff <= ha_in;  hg_ff <= hg_in;  hb_ff <= hb_in;  hv_ff <= hv_in;  hs_ff <= hs_in;
   end

   assign idle      = step_ff == S_IDLE;
   assign res_valid = step_ff == S_DONE;
   assign result.fine_temp    = fine_out_ff;
   assign result.temp_ok      = tok_ff;
   assign result.pressure_q5  = press_out_ff;
   assign result.press_ok     = pok_ff;
   assign result.humidity_q10 = hum_out_ff;
   assign result.hum_ok       = hok_ff;

endmodule

### rtl/core/env_sensor_trim_compensation.sv
// A reading with all channels measured takes 21 products in the shared multiplier
// and one pressure division, then the done state, in which the result register loads it.
// A new reading is accepted only once the sequencer is idle again, after its result
// has been taken; skipped channels shorten the work and a held-off response delays it.
// Reset (synchronous, active high) clears the trim registers, held fine temp and handshakes.
// ============================================================================
// Environmental sensor trim compensation
// Configuration registers, stream ports and result register around the
// sequencer and the shared arithmetic unit.
// ============================================================================
`timescale 1ns / 1ps
`include "env_sensor_trim_compensation_defines.svh"

module env_sensor_trim_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // raw_temp[23:0], raw_press[47:24], raw_hum[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // fine_temp[31:0], pressure_q5[63:32], humidity_q10[80:64]
   output logic [2:0]  rsp_tuser,   // temp_ok[0], press_ok[1], hum_ok[2]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   estc_pkg::trim_type      trim_ff, trim_in;
   estc_pkg::result_type    out_ff, out_in;
   estc_pkg::result_type    seq_result;
   estc_pkg::arith_cmd_type cmd;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    seq_idle, seq_valid, take;
   logic [63:0]             opa, opb, arith_res;
   logic                    arith_done;

   // Configuration writes.
   assign csr_ready = 1'b1;
   always_comb begin
      trim_in = trim_ff;
      if (csr_valid) begin
         unique case (csr_index)
            estc_pkg::CSR_TEMP_TRIM:       trim_in.temp_trim       = csr_data[47:0];
            estc_pkg::CSR_PRESS_TRIM_LOW:  trim_in.press_trim_low  = csr_data;
            estc_pkg::CSR_PRESS_TRIM_HIGH: trim_in.press_trim_high = csr_data;
            estc_pkg::CSR_PRESS_TRIM_NINE: trim_in.press_trim_nine = csr_data[15:0];
            estc_pkg::CSR_HUM_TRIM:        trim_in.hum_trim        = csr_data;
            estc_pkg::CSR_HUM_PRESENT:     trim_in.humidity_present = csr_data[0];
            default:                       trim_in = trim_ff;
         endcase
      end
   end

   // Result register: takes a finished result when empty or being drained.
   assign take = seq_valid && (!rsp_valid_ff || rsp_tready);
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         out_in       = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         trim_ff      <= trim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   estc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid && req_tready),
      .raw_temp   (req_tdata[23:0]),
      .raw_press  (req_tdata[47:24]),
      .raw_hum    (req_tdata[63:48]),
      .trim       (trim_ff),
      .take       (take),
      .idle       (seq_idle),
      .res_valid  (seq_valid),
      .result     (seq_result),
      .cmd        (cmd),
      .opa        (opa),
      .opb        (opb),
      .arith_done (arith_done),
      .arith_res  (arith_res)
   );

   estc_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (arith_done),
      .result (arith_res)
   );

   assign req_tready = seq_idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.humidity_q10, out_ff.pressure_q5, out_ff.fine_temp};
   assign rsp_tuser  = {out_ff.hum_ok, out_ff.press_ok, out_ff.temp_ok};

   // A reading that was just accepted keeps the input closed while it is worked.
   `ESTC_CHECK_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "input open while busy")
   // Humidity never leaves the 0..100 percent range.
   `ESTC_CHECK_SAME(a_hum_range, rsp_tvalid && rsp_tuser[2], rsp_tdata[80:64] <= estc_pkg::HUM_Q10_MAX, "humidity out of range")
   // A skipped pressure channel reports zero.
   `ESTC_CHECK_SAME(a_press_skip, rsp_tvalid && !rsp_tuser[1], rsp_tdata[63:32] == 32'd0, "skipped pressure nonzero")

endmodule

### tb/env_sensor_trim_compensation_tb.sv
// ============================================================================
// Trim compensation block testbench
// Sends raw temperature, pressure and humidity readings over the request
// stream and checks every response against a bit-exact integer predictor.
// Several trim sets are loaded, including all-ones, after the all-zero reset
// set; both stream sides idle at random, with one long response hold-off.
// ============================================================================
`timescale 1ns / 1ps

module env_sensor_trim_compensation_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 250;
   localparam int LONG_HOLD      = 3000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // Predictor copy of the trim registers and the held fine temperature.
   logic [47:0] temp_trim;
   logic [63:0] press_lo;
   logic [63:0] press_hi;
   logic [15:0] press_p9;
   logic [63:0] hum_trim;
   logic        hum_present;
   logic [31:0] held_fine;

   estc_pkg::result_type expected_readings[$];
   int          mismatch_count;
   bit          no_idle;
   bit          hold_request;

   env_sensor_trim_compensation i_dut (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] shr64(input logic [63:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] shr32(input logic [31:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   // Signed division truncating toward zero; the quotient wraps on overflow.
   function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q  = an / ad;
      return (n[63] ^ d[63]) ? -q : q;
   endfunction

   function automatic logic [31:0] fine_of(input logic [23:0] raw);
      logic [63:0] adc, t1, t2, t3, d1, d2, v1, v2, sum;
      adc = {44'd0, raw[23:4]};
      t1  = {48'd0, temp_trim[15:0]};
      t2  = {{48{temp_trim[31]}}, temp_trim[31:16]};
      t3  = {{48{temp_trim[47]}}, temp_trim[47:32]};
      d1  = (adc >> 3) - (t1 << 1);
      v1  = shr64(d1 * t2, 11);
      d2  = (adc >> 4) - t1;
      v2  = shr64(shr64(d2 * d2, 12) * t3, 14);
      sum = v1 + v2;
      return sum[31:0];
   endfunction

   function automatic logic [31:0] pressure_of(input logic [31:0] fine, input logic [23:0] raw);
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, s, p7s;
      logic [31:0] ps;
      p1 = {48'd0, press_lo[15:0]};
      p2 = {{48{press_lo[31]}}, press_lo[31:16]};
      p3 = {{48{press_lo[47]}}, press_lo[47:32]};
      p4 = {{48{press_lo[63]}}, press_lo[63:48]};
      p5 = {{48{press_hi[15]}}, press_hi[15:0]};
      p6 = {{48{press_hi[31]}}, press_hi[31:16]};
      p7 = {{48{press_hi[47]}}, press_hi[47:32]};
      p8 = {{48{press_hi[63]}}, press_hi[63:48]};
      p9 = {{48{press_p9[15]}}, press_p9};
      a = {{32{fine[31]}}, fine} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = shr64(a * a * p3, 8) + ((a * p2) << 12);
      a = shr64(((64'd1 << 47) + a) * p1, 33);
      // A zero divisor forces the fallback pressure.
      if (a == 64'd0) return estc_pkg::PRESS_FALLBACK;
      p = 64'd1048576 - {44'd0, raw[23:4]};
      p = div_trunc(((p << 31) - b) * 64'd3125, a);
      a = shr64(p9 * shr64(p, 13) * shr64(p, 13), 25);
      b = shr64(p8 * p, 19);
      s = shr64(p + a + b, 8);
      p7s = p7 << 4;
      ps = s[31:0] + p7s[31:0];
      return shr32(ps, 3);
   endfunction

   function automatic logic [16:0] humidity_of(input logic [31:0] fine, input logic [15:0] raw);
      logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, v, s;
      h1 = {24'd0, hum_trim[7:0]};
      h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
      h3 = {24'd0, hum_trim[31:24]};
      h4 = {20'd0, hum_trim[43:32]};
      h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
      h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};
      x  = fine - 32'd76800;
      a  = ({16'd0, raw} << 14) - (h4 << 20) - (h5 * x) + 32'd16384;
      a  = shr32(a, 15);
      b  = shr32(x * h6, 10) * (shr32(x * h3, 11) + 32'd32768);
      b  = shr32(b, 10) + 32'd2097152;
      b  = shr32(b * h2 + 32'd8192, 14);
      v  = a * b;
      s  = shr32(v, 15);
      v  = v - shr32(shr32(s * s, 7) * h1, 4);
      // Clamp to 0..100 percent before dropping the extra fraction bits.
      if (v[31]) v = 32'd0;
      if (v > estc_pkg::HUM_RAW_MAX) v = estc_pkg::HUM_RAW_MAX;
      return v[28:12];
   endfunction

   // Works out the response for one accepted reading and updates held state.
   function automatic estc_pkg::result_type compensate(input logic [63:0] d);
      estc_pkg::result_type r;
      logic [23:0] rt, rp;
      logic [15:0] rh;
      rt = d[23:0];
      rp = d[47:24];
      rh = d[63:48];
      r = '0;
      r.temp_ok  = (rt != estc_pkg::SKIP24);
      r.press_ok = (rp != estc_pkg::SKIP24);
      r.hum_ok   = hum_present && (rh != estc_pkg::SKIP16);
      if (r.temp_ok) begin
         r.fine_temp = fine_of(rt);
         held_fine   = r.fine_temp;
      end
      if (r.press_ok) r.pressure_q5 = pressure_of(held_fine, rp);
      if (r.hum_ok) r.humidity_q10 = humidity_of(held_fine, rh);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 40) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // Sends one reading; called at a falling edge, returns at a falling edge.
   task automatic send_reading(input logic [23:0] rt, input logic [23:0] rp,
                               input logic [15:0] rh);
      int gap;
      req_tdata  <= {rh, rp, rt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_readings.push_back(compensate({rh, rp, rt}));
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits for the block to go idle, then performs one register transaction.
   task automatic write_trim(input logic [2:0] idx, input logic [63:0] value);
      req_tvalid <= 1'b0;
      wait (expected_readings.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         estc_pkg::CSR_TEMP_TRIM:       temp_trim   = value[47:0];
         estc_pkg::CSR_PRESS_TRIM_LOW:  press_lo    = value;
         estc_pkg::CSR_PRESS_TRIM_HIGH: press_hi    = value;
         estc_pkg::CSR_PRESS_TRIM_NINE: press_p9    = value[15:0];
         estc_pkg::CSR_HUM_TRIM:        hum_trim    = value;
         estc_pkg::CSR_HUM_PRESENT:     hum_present = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_trims(input logic [47:0] t, input logic [63:0] pl, input logic [63:0] ph,
                             input logic [15:0] p9, input logic [63:0] h, input logic hp);
      write_trim(estc_pkg::CSR_TEMP_TRIM, {16'd0, t});
      write_trim(estc_pkg::CSR_PRESS_TRIM_LOW, pl);
      write_trim(estc_pkg::CSR_PRESS_TRIM_HIGH, ph);
      write_trim(estc_pkg::CSR_PRESS_TRIM_NINE, {48'd0, p9});
      write_trim(estc_pkg::CSR_HUM_TRIM, h);
      write_trim(estc_pkg::CSR_HUM_PRESENT, {63'd0, hp});
   endtask

   // Typical factory coefficients.
   task automatic load_typical_trims(input logic hp);
      load_trims({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 16'd6000,
                 {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75}, hp);
   endtask

   // Mostly plausible readings with a share of arbitrary values and skips.
   task automatic send_random_reading();
      logic [23:0] rt, rp;
      logic [15:0] rh;
      if ($urandom_range(0, 9) < 3) begin
         rt = 24'($urandom);
         rp = 24'($urandom);
         rh = 16'($urandom);
      end else begin
         rt = {20'($urandom_range(380000, 620000)), 4'($urandom)};
         rp = {20'($urandom_range(200000, 450000)), 4'($urandom)};
         rh = 16'($urandom_range(10000, 50000));
      end
      if ($urandom_range(0, 19) == 0) rt = estc_pkg::SKIP24;
      if ($urandom_range(0, 19) == 0) rp = estc_pkg::SKIP24;
      if ($urandom_range(0, 19) == 0) rh = estc_pkg::SKIP16;
      send_reading(rt, rp, rh);
   endtask

   task automatic test_reset_trims();
      // All-zero trims after reset give a zero pressure divisor.
      send_reading(24'h000000, 24'h000000, 16'h0000);
      send_reading(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      send_reading(24'h512340, 24'h654320, 16'h6A5B);
   endtask

   task automatic test_directed();
      load_typical_trims(1'b1);
      send_reading(24'h7E1230, 24'h5A3B40, 16'h6F00);
      send_reading(24'h000000, 24'h000000, 16'h0000);
      send_reading(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      send_reading(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
      send_reading(24'h800001, 24'h800001, 16'h8001);
      // Temperature skipped: the held fine value is used.
      send_reading(estc_pkg::SKIP24, 24'h5A3B40, 16'h6F00);
      send_reading(24'h7E1230, estc_pkg::SKIP24, 16'h6F00);
      send_reading(24'h7E1230, 24'h5A3B40, estc_pkg::SKIP16);
      send_reading(estc_pkg::SKIP24, estc_pkg::SKIP24, estc_pkg::SKIP16);
      // Readings that drive humidity to both clamp limits.
      send_reading(24'h7E1230, 24'h5A3B40, 16'hF000);
      send_reading(24'h7E1230, 24'h5A3B40, 16'h0100);
      send_reading(24'h100000, 24'h5A3B40, 16'h6F00);
      send_reading(24'hF00000, 24'h5A3B40, 16'h6F00);
      // Humidity absent in the part.
      write_trim(estc_pkg::CSR_HUM_PRESENT, 64'd0);
      send_reading(24'h7E1230, 24'h5A3B40, 16'h6F00);
      send_reading(estc_pkg::SKIP24, 24'h5A3B40, estc_pkg::SKIP16);
      write_trim(estc_pkg::CSR_HUM_PRESENT, 64'd1);
   endtask

   task automatic test_typical_random();
      no_idle = 1'b1;
      repeat (100) send_random_reading();
      no_idle = 1'b0;
      repeat (650) send_random_reading();
   endtask

   task automatic test_random_trims();
      repeat (6) begin
         load_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom), {$urandom, $urandom}, $urandom_range(0, 3) != 0);
         repeat (110) send_random_reading();
      end
   endtask

   task automatic test_extreme_trims();
      load_trims('1, '1, '1, '1, '1, 1'b1);
      repeat (60) send_random_reading();
      load_trims({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                 {4{16'h7FFF}}, 16'h7FFF,
                 {8'h80, 12'h800, 12'hFFF, 8'hFF, 16'h8000, 8'hFF}, 1'b1);
      repeat (60) send_random_reading();
      load_trims({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                 {4{16'h8000}}, 16'h8000,
                 {8'h7F, 12'h7FF, 12'h000, 8'h00, 16'h7FFF, 8'h00}, 1'b1);
      repeat (60) send_random_reading();
   endtask

   task automatic test_backpressure();
      load_typical_trims(1'b1);
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      repeat (40) send_random_reading();
   endtask

   // Response side readiness, with random stalls and one long hold-off.
   initial begin : rsp_ready_driver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compares each response transaction with the oldest expectation.
   always @(posedge clock) begin
      estc_pkg::result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected response %h", rsp_tdata);
         end else begin
            e = expected_readings.pop_front();
            if (rsp_tdata[31:0] !== e.fine_temp || rsp_tdata[63:32] !== e.pressure_q5 ||
                rsp_tdata[80:64] !== e.humidity_q10 ||
                rsp_tuser !== {e.hum_ok, e.press_ok, e.temp_ok}) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Response mismatch: expected fine %h press %h hum %h ok %b%b%b,",
                            " got fine %h press %h hum %h ok %b"},
                           e.fine_temp, e.pressure_q5, e.humidity_q10, e.hum_ok, e.press_ok,
                           e.temp_ok, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[80:64],
                           rsp_tuser);
            end
         end
      end
   end

   // Ends the run when no transaction happens on any port for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : main_sequence
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      temp_trim      = '0;
      press_lo       = '0;
      press_hi       = '0;
      press_p9       = '0;
      hum_trim       = '0;
      hum_present    = 1'b0;
      held_fine      = '0;
      mismatch_count = 0;
      no_idle        = 1'b0;
      hold_request   = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_trims();
      test_directed();
      test_typical_random();
      test_random_trims();
      test_extreme_trims();
      test_backpressure();
      req_tvalid <= 1'b0;
      wait (expected_readings.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
